// File: rtl/ckse_pkg.sv
// ----------------------------------------------------------------------------
// ckse_pkg: shared types and constants for the key sequence encoder
// Word layouts, byte constants and the ctrl key mapping.
// ----------------------------------------------------------------------------
package ckse_pkg;

    localparam int CP_W   = 21;                    // codepoint width
    localparam int MOD_W  = 3;                     // modifier flags
    localparam int LVL_W  = 2;                     // modify-other-keys level
    localparam int DIG_N  = 7;                     // decimal digits of a codepoint
    localparam int BCD_W  = 4 * DIG_N;
    localparam int CNT_W  = $clog2(CP_W + 1);      // conversion step counter
    localparam int DCNT_W = $clog2(DIG_N + 1);     // digit counter
    localparam int CONT_W = 18;                    // UTF-8 continuation payload bits

    localparam logic [CP_W-1:0] CP_MAX = CP_W'(21'h10FFFF);
    localparam logic [CP_W-1:0] CP_SPACE = CP_W'(8'h20);
    localparam logic [CP_W-1:0] CP_DEL   = CP_W'(8'h7F);

    localparam logic [7:0] B_ESC   = 8'h1B;
    localparam logic [7:0] B_LBRK  = 8'h5B;        // '['
    localparam logic [7:0] B_TWO   = 8'h32;        // '2'
    localparam logic [7:0] B_SEVEN = 8'h37;        // '7'
    localparam logic [7:0] B_SEMI  = 8'h3B;        // ';'
    localparam logic [7:0] B_TILDE = 8'h7E;        // '~'

    localparam int MOD_SHIFT = 0;
    localparam int MOD_ALT   = 1;
    localparam int MOD_CTRL  = 2;

    typedef struct packed {
        logic [CP_W-1:0]  codepoint;
        logic [MOD_W-1:0] modifiers;
    } t_in_word;

    typedef struct packed {
        logic [7:0] output_byte;
        logic       last_byte;
    } t_out_word;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } t_ctl_map;

    // Ctrl-key mapping of a printable ASCII codepoint.
    function automatic t_ctl_map ckse_ctrl_map(input logic [CP_W-1:0] cp);
        t_ctl_map   res;
        logic [7:0] c;
        res = '{hit: 1'b0, code: 8'h00};
        c   = {1'b0, cp[6:0]};
        if (cp[CP_W-1:7] == '0) begin
            priority if (c >= 8'h61 && c <= 8'h7A) begin
                res = '{hit: 1'b1, code: c - 8'h60};
            end else if (c >= 8'h41 && c <= 8'h5A) begin
                res = '{hit: 1'b1, code: c - 8'h40};
            end else begin
                unique case (c)
                    8'h20, 8'h40, 8'h32:         res = '{hit: 1'b1, code: 8'h00};
                    8'h5B, 8'h7B, 8'h33:         res = '{hit: 1'b1, code: 8'h1B};
                    8'h5C, 8'h7C, 8'h34:         res = '{hit: 1'b1, code: 8'h1C};
                    8'h5D, 8'h7D, 8'h35:         res = '{hit: 1'b1, code: 8'h1D};
                    8'h5E, 8'h7E, 8'h36:         res = '{hit: 1'b1, code: 8'h1E};
                    8'h5F, 8'h2D, 8'h2F, 8'h37:  res = '{hit: 1'b1, code: 8'h1F};
                    8'h3F, 8'h38:                res = '{hit: 1'b1, code: 8'h7F};
                    default:                     res = '{hit: 1'b0, code: 8'h00};
                endcase
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/codepoint_key_sequence_encoder.sv
// ----------------------------------------------------------------------------
// codepoint_key_sequence_encoder
// Turns a typed character (codepoint + shift/alt/ctrl) into terminal bytes.
// ----------------------------------------------------------------------------
// One input word is one keystroke; the block answers with the byte sequence a
// terminal would see, one byte per output word, last_byte set on the final
// one. With modify-other-keys on (level 1: alt/ctrl combos, level 2 or 3: any
// modifier) a printable key is sent as ESC [ 2 7 ; m ; <decimal cp> ~. Else a
// ctrl key with a mapping sends its control byte (NUL included), ESC first if
// alt is held. Else the codepoint goes out as UTF-8, ESC first if alt is held.
// A zero codepoint, or a UTF-8 codepoint above 0x10FFFF, gives no bytes.
// Timing: a word is taken while idle, then one byte per cycle goes into the
// output register while i_stall allows. Ctrl and UTF-8 keys hold the input
// until their bytes (1 to 5) are out. The CSI 27 form runs a 21-step
// shift-add-3 binary to BCD converter, started at acceptance and overlapped
// with the seven prefix bytes; digits wait on it, and the seven digit places
// are taken in turn, leading zeros skipped without a byte. The next word is
// taken as soon as the final byte has been loaded, even while it still waits
// downstream.
// ----------------------------------------------------------------------------
module codepoint_key_sequence_encoder
    import ckse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // keystroke input
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_word         i_in,
    // byte output
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_word        o_out,
    // modify-other-keys level
    input  logic             i_cfg_we,
    input  logic [LVL_W-1:0] i_cfg_wdata
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ESC   = 7'b0000010,   // ESC prefix
        S_CSI   = 7'b0000100,   // "[27;m;"
        S_DIG   = 7'b0001000,   // decimal codepoint
        S_TILDE = 7'b0010000,
        S_LEAD  = 7'b0100000,   // control byte or UTF-8 lead byte
        S_CONT  = 7'b1000000    // UTF-8 continuation bytes
    } t_state;

    t_state               r_state, n_state;
    logic [LVL_W-1:0]     r_level;
    logic                 r_ovalid, n_ovalid;
    t_out_word            r_out, n_out;
    logic                 r_csi, n_csi;
    logic [7:0]           r_lead, n_lead;     // ctl byte, UTF-8 lead, or '0'+m
    logic [2:0]           r_idx, n_idx;       // CSI byte index / continuations left
    logic [CONT_W-1:0]    r_sh, n_sh;         // continuation bits, msb aligned
    logic [CP_W-1:0]      r_bin, n_bin;       // converter input shifter
    logic [BCD_W-1:0]     r_bcd, n_bcd;       // converter digits
    logic [CNT_W-1:0]     r_cnt, n_cnt;       // converter steps left
    logic [DCNT_W-1:0]    r_dcnt, n_dcnt;     // digit places left
    logic                 r_nz, n_nz;         // a digit has been sent

    logic                 w_acc;
    logic                 w_slot;
    logic                 w_emit;
    logic [7:0]           w_byte;
    logic                 w_last;
    logic                 w_alt;
    logic                 w_ctrl;
    logic                 w_use_csi;
    t_ctl_map             w_map;
    logic [BCD_W-1:0]     w_adj;
    logic [3:0]           w_top;
    logic [CP_W-1:0]      w_cp;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    assign w_acc  = i_valid && (r_state == S_IDLE);
    assign w_slot = !r_ovalid || !i_stall;
    assign w_cp   = i_in.codepoint;
    assign w_alt  = i_in.modifiers[MOD_ALT];
    assign w_ctrl = i_in.modifiers[MOD_CTRL];
    assign w_map  = ckse_ctrl_map(w_cp);
    assign w_top  = r_bcd[BCD_W-1 -: 4];

    // level 3 acts as level 2
    assign w_use_csi = (r_level != '0) && (i_in.modifiers != '0) &&
                       (w_cp >= CP_SPACE) && (w_cp != CP_DEL) &&
                       !((r_level == LVL_W'(1)) && !w_alt && !w_ctrl);

    // add-3 correction for every BCD digit
    always_comb begin
        for (int i = 0; i < DIG_N; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                        : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_csi    = r_csi;
        n_lead   = r_lead;
        n_idx    = r_idx;
        n_sh     = r_sh;
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_dcnt   = r_dcnt;
        n_nz     = r_nz;
        w_emit   = 1'b0;
        w_byte   = 8'h00;
        w_last   = 1'b0;

        // converter: one bit per cycle
        if (r_cnt != '0) begin
            n_bcd = {w_adj[BCD_W-2:0], r_bin[CP_W-1]};
            n_bin = {r_bin[CP_W-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc && w_cp != '0) begin
                    n_idx = '0;
                    priority if (w_use_csi) begin
                        n_csi   = 1'b1;
                        n_bin   = w_cp;
                        n_bcd   = '0;
                        n_cnt   = CNT_W'(CP_W);
                        n_dcnt  = DCNT_W'(DIG_N);
                        n_nz    = 1'b0;
                        n_lead  = {4'h3, {1'b0, i_in.modifiers} + 4'd1};
                        n_state = S_ESC;
                    end else if (w_ctrl && w_map.hit) begin
                        n_csi   = 1'b0;
                        n_lead  = w_map.code;
                        n_state = w_alt ? S_ESC : S_LEAD;
                    end else if (w_cp <= CP_MAX) begin
                        n_csi   = 1'b0;
                        priority if (w_cp < CP_W'(21'h80)) begin
                            n_lead = {1'b0, w_cp[6:0]};
                            n_sh   = '0;
                            n_idx  = 3'd0;
                        end else if (w_cp < CP_W'(21'h800)) begin
                            n_lead = {3'b110, w_cp[10:6]};
                            n_sh   = {w_cp[5:0], 12'h000};
                            n_idx  = 3'd1;
                        end else if (w_cp < CP_W'(21'h10000)) begin
                            n_lead = {4'b1110, w_cp[15:12]};
                            n_sh   = {w_cp[11:0], 6'h00};
                            n_idx  = 3'd2;
                        end else begin
                            n_lead = {5'b11110, w_cp[20:18]};
                            n_sh   = w_cp[17:0];
                            n_idx  = 3'd3;
                        end
                        n_state = w_alt ? S_ESC : S_LEAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ESC: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    w_byte  = B_ESC;
                    n_state = r_csi ? S_CSI : S_LEAD;
                end
            end
            S_CSI: begin
                if (w_slot) begin
                    w_emit = 1'b1;
                    unique case (r_idx)
                        3'd0:    w_byte = B_LBRK;
                        3'd1:    w_byte = B_TWO;
                        3'd2:    w_byte = B_SEVEN;
                        3'd4:    w_byte = r_lead;
                        default: w_byte = B_SEMI;
                    endcase
                    if (r_idx == 3'd5) begin
                        n_state = S_DIG;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            S_DIG: begin
                if (r_cnt == '0) begin
                    // drop leading zeros, always keep the last place
                    if (!r_nz && w_top == 4'd0 && r_dcnt > DCNT_W'(1)) begin
                        n_bcd  = {r_bcd[BCD_W-5:0], 4'h0};
                        n_dcnt = r_dcnt - DCNT_W'(1);
                    end else if (w_slot) begin
                        w_emit = 1'b1;
                        w_byte = {4'h3, w_top};
                        n_nz   = 1'b1;
                        n_bcd  = {r_bcd[BCD_W-5:0], 4'h0};
                        n_dcnt = r_dcnt - DCNT_W'(1);
                        if (r_dcnt == DCNT_W'(1)) begin
                            n_state = S_TILDE;
                        end
                    end
                end
            end
            S_TILDE: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    w_byte  = B_TILDE;
                    w_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LEAD: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    w_byte  = r_lead;
                    w_last  = (r_idx == 3'd0);
                    n_state = (r_idx == 3'd0) ? S_IDLE : S_CONT;
                end
            end
            S_CONT: begin
                if (w_slot) begin
                    w_emit = 1'b1;
                    w_byte = {2'b10, r_sh[CONT_W-1 -: 6]};
                    w_last = (r_idx == 3'd1);
                    n_sh   = {r_sh[CONT_W-7:0], 6'h00};
                    n_idx  = r_idx - 3'd1;
                    if (r_idx == 3'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_ovalid = r_ovalid;
        n_out    = r_out;
        if (w_emit) begin
            n_ovalid = 1'b1;
            n_out    = '{output_byte: w_byte, last_byte: w_last};
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_level  <= '0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            if (i_cfg_we) begin
                r_level <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_csi  <= n_csi;
        r_lead <= n_lead;
        r_idx  <= n_idx;
        r_sh   <= n_sh;
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_dcnt <= n_dcnt;
        r_nz   <= n_nz;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_dig_after_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG && w_emit) |-> (r_cnt == '0))
        else $error("digit sent before conversion finished");

    a_dig_places: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG) |-> (r_dcnt != '0))
        else $error("digit state with no places left");

    a_conv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CP_W))
        else $error("converter step count out of range");

    a_zero_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_cp == '0) |=> (r_state == S_IDLE && !$rose(r_ovalid)))
        else $error("zero codepoint produced output");

    a_cont_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONT) |-> (r_idx != 3'd0 && r_idx <= 3'd3))
        else $error("bad continuation count");

endmodule
